/* sv/qtt_pkg.sv */
// shared types, constants and saturating helpers for the quadrotor thrust and torque step
`timescale 1ns / 1ps
`default_nettype none
package qtt_pkg;

	// number format
	localparam int WORD_W     = 32;
	localparam int FRAC_BITS  = 16;
	localparam int CONST_FRAC = 40;
	localparam int ACC_W      = 64;
	localparam int HALF_W     = ACC_W / 2;
	localparam int PROD_W     = 2 * ACC_W;
	localparam int UWORD_W    = WORD_W - 1;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = WORD_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIME_STEP     = 3'd0,
		CFG_LOW_THROTTLE  = 3'd1,
		CFG_MAX_BODY_RATE = 3'd2,
		CFG_THRUST_RATE   = 3'd3,
		CFG_LAG_GAIN      = 3'd4,
		CFG_CEIL_OFFSET   = 3'd5,
		CFG_CEIL_GAIN     = 3'd6,
		CFG_ATT_GAIN      = 3'd7
	} cfg_reg_t;

	// register reset values
	localparam logic [UWORD_W-1:0]       RST_TIME_STEP     = UWORD_W'(66);
	localparam logic [UWORD_W-1:0]       RST_LOW_THROTTLE  = UWORD_W'(19660800);
	localparam logic [UWORD_W-1:0]       RST_MAX_BODY_RATE = UWORD_W'(171573);
	localparam logic [UWORD_W-1:0]       RST_THRUST_RATE   = UWORD_W'(3067111);
	localparam logic signed [WORD_W-1:0] RST_LAG_GAIN      = WORD_W'(201406);
	localparam logic signed [WORD_W-1:0] RST_CEIL_OFFSET   = -WORD_W'(1179694);
	localparam logic signed [WORD_W-1:0] RST_CEIL_GAIN     = WORD_W'(277711);
	localparam logic signed [WORD_W-1:0] RST_ATT_GAIN      = WORD_W'(11783176);

	// model coefficients, 40 fraction bits
	localparam logic signed [ACC_W-1:0] K_PQ0  = -64'sd357407250;
	localparam logic signed [ACC_W-1:0] K_PQ2  = -64'sd26777066378206;
	localparam logic signed [ACC_W-1:0] K_R0   = -64'sd5297260106;
	localparam logic signed [ACC_W-1:0] K_R1   = -64'sd5595898458868;
	localparam logic signed [ACC_W-1:0] K_CTH0 = 64'sd729944878960;
	localparam logic signed [ACC_W-1:0] K_CTH1 = 64'sd818750234;
	localparam logic signed [ACC_W-1:0] K_CTH2 = 64'sd2637234;

	// constant thrust term: one times CTH0, rounded (CTH0 is positive)
	localparam logic signed [ACC_W-1:0] CTH0_TERM =
		(K_CTH0 + (64'sd1 <<< (CONST_FRAC - FRAC_BITS - 1))) >>> (CONST_FRAC - FRAC_BITS);

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] WORD_MAX_L = (64'sd1 <<< (WORD_W - 1)) - 64'sd1;
	localparam logic signed [ACC_W-1:0] WORD_MIN_L = -WORD_MAX_L - 64'sd1;

	// transaction payloads
	typedef struct packed {
		logic [UWORD_W-1:0]       throttle_cmd;
		logic [UWORD_W-1:0]       supply_voltage;
		logic signed [WORD_W-1:0] roll_cmd;
		logic signed [WORD_W-1:0] pitch_cmd;
		logic signed [WORD_W-1:0] yaw_cmd;
		logic signed [WORD_W-1:0] roll_angle;
		logic signed [WORD_W-1:0] pitch_angle;
		logic signed [WORD_W-1:0] rate_x;
		logic signed [WORD_W-1:0] rate_y;
		logic signed [WORD_W-1:0] rate_z;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] thrust_out;
		logic signed [WORD_W-1:0] torque_x;
		logic signed [WORD_W-1:0] torque_y;
		logic signed [WORD_W-1:0] torque_z;
	} out_item_t;

	// request to the shared multiplier
	typedef struct packed {
		logic start;
		logic long_shift;
	} mul_req_t;

	typedef enum logic [1:0] {
		M_IDLE,
		M_MAC,
		M_DRAIN,
		M_FIN
	} mul_state_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_TT,
		ST_C1,
		ST_C2,
		ST_ERR,
		ST_LAG1,
		ST_LAG2,
		ST_LIM,
		ST_CEIL,
		ST_CLAMP,
		ST_CAND,
		ST_CAP,
		ST_TQ1,
		ST_TQ2,
		ST_TQ3,
		ST_TQ4,
		ST_YAW1,
		ST_YAW2,
		ST_OUT
	} qtt_state_t;

	function automatic logic signed [ACC_W-1:0] zext_u(input logic [UWORD_W-1:0] x);
		zext_u = {{(ACC_W-UWORD_W){1'b0}}, x};
	endfunction

	function automatic logic signed [ACC_W-1:0] sext_s(input logic [WORD_W-1:0] x);
		sext_s = {{(ACC_W-WORD_W){x[WORD_W-1]}}, x};
	endfunction

	function automatic logic signed [ACC_W-1:0] add_sat(
		input logic signed [ACC_W-1:0] x,
		input logic signed [ACC_W-1:0] y
	);
		logic [ACC_W:0] s;
		s = {x[ACC_W-1], x} + {y[ACC_W-1], y};
		if (s[ACC_W] != s[ACC_W-1]) begin
			add_sat = s[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			add_sat = s[ACC_W-1:0];
		end
	endfunction

	function automatic logic signed [ACC_W-1:0] sub_sat(
		input logic signed [ACC_W-1:0] x,
		input logic signed [ACC_W-1:0] y
	);
		logic [ACC_W:0] s;
		s = {x[ACC_W-1], x} - {y[ACC_W-1], y};
		if (s[ACC_W] != s[ACC_W-1]) begin
			sub_sat = s[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			sub_sat = s[ACC_W-1:0];
		end
	endfunction

	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] x);
		if (x > WORD_MAX_L) begin
			sat_word = WORD_MAX_L[WORD_W-1:0];
		end else if (x < WORD_MIN_L) begin
			sat_word = WORD_MIN_L[WORD_W-1:0];
		end else begin
			sat_word = x[WORD_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

/* sv/qtt_mul.sv */
// shared multiply, round and saturate unit built on one 32x32 multiplier
`timescale 1ns / 1ps
`default_nettype none
module qtt_mul (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire qtt_pkg::mul_req_t                req,
	input  wire logic signed [qtt_pkg::ACC_W-1:0] a,
	input  wire logic signed [qtt_pkg::ACC_W-1:0] b,
	output logic                                  done,
	output logic signed [qtt_pkg::ACC_W-1:0]      result
);
	import qtt_pkg::*;

	mul_state_t state_q, state_d;

	logic [ACC_W-1:0]        ua_q, ub_q;
	logic                    neg_q, long_q;
	logic [3:0]              pend_q;
	logic [ACC_W-1:0]        prod_s1;
	logic [1:0]              pos_s1;
	logic                    pv_s1;
	logic [PROD_W-1:0]       acc_q;
	logic signed [ACC_W-1:0] result_q;
	logic                    done_q;

	logic [ACC_W-1:0]  a_mag, b_mag;
	logic [1:0]        pair;
	logic [3:0]        pend_left;
	logic [HALF_W-1:0] a_half, b_half;
	logic [PROD_W-1:0] addend, acc_sum, round_c, shifted;
	logic [ACC_W-1:0]  hi, lo, limit;
	logic signed [ACC_W-1:0] fin_res;
	logic              issue;

	// magnitudes, partial product pick, accumulate and final scaling
	always_comb begin
		a_mag = a[ACC_W-1] ? $unsigned(-a) : $unsigned(a);
		b_mag = b[ACC_W-1] ? $unsigned(-b) : $unsigned(b);

		if (pend_q[0]) begin
			pair = 2'd0;
		end else if (pend_q[1]) begin
			pair = 2'd1;
		end else if (pend_q[2]) begin
			pair = 2'd2;
		end else begin
			pair = 2'd3;
		end
		pend_left = pend_q & ~(4'b0001 << pair);
		a_half = pair[1] ? ua_q[ACC_W-1:HALF_W] : ua_q[HALF_W-1:0];
		b_half = pair[0] ? ub_q[ACC_W-1:HALF_W] : ub_q[HALF_W-1:0];

		case (pos_s1)
			2'd0:    addend = {{ACC_W{1'b0}}, prod_s1};
			2'd1:    addend = {{HALF_W{1'b0}}, prod_s1, {HALF_W{1'b0}}};
			default: addend = {prod_s1, {ACC_W{1'b0}}};
		endcase
		acc_sum = acc_q + addend;

		round_c = req.long_shift ? (PROD_W'(1) << (CONST_FRAC - 1))
		                         : (PROD_W'(1) << (FRAC_BITS - 1));

		shifted = long_q ? (acc_q >> CONST_FRAC) : (acc_q >> FRAC_BITS);
		hi = shifted[PROD_W-1:ACC_W];
		lo = shifted[ACC_W-1:0];
		limit = neg_q ? $unsigned(ACC_MIN) : $unsigned(ACC_MAX);
		if ((hi != '0) || (lo > limit)) begin
			fin_res = neg_q ? ACC_MIN : ACC_MAX;
		end else begin
			fin_res = neg_q ? -$signed(lo) : $signed(lo);
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		case (state_q)
			M_IDLE: begin
				if (req.start) state_d = M_MAC;
			end
			M_MAC: begin
				issue = 1'b1;
				if (pend_left == '0) state_d = M_DRAIN;
			end
			M_DRAIN: begin
				state_d = M_FIN;
			end
			M_FIN: begin
				state_d = M_IDLE;
			end
			default: begin
				state_d = M_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			pv_s1   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pv_s1   <= issue;
			done_q  <= (state_q == M_FIN);
		end
	end

	// operand, product and accumulator registers
	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && req.start) begin
			ua_q   <= a_mag;
			ub_q   <= b_mag;
			neg_q  <= a[ACC_W-1] ^ b[ACC_W-1];
			long_q <= req.long_shift;
			pend_q <= {(a_mag[ACC_W-1:HALF_W] != '0) && (b_mag[ACC_W-1:HALF_W] != '0),
			           a_mag[ACC_W-1:HALF_W] != '0,
			           b_mag[ACC_W-1:HALF_W] != '0,
			           1'b1};
			acc_q  <= round_c;
		end else begin
			if (pv_s1) acc_q <= acc_sum;
			if (issue) pend_q <= pend_left;
		end
		if (issue) begin
			prod_s1 <= ACC_W'(a_half) * ACC_W'(b_half);
			pos_s1  <= 2'(pair[1]) + 2'(pair[0]);
		end
		if (state_q == M_FIN) result_q <= fin_res;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

/* sv/quadrotor_thrust_torque_step_core.sv */
// quadrotor thrust and torque step: sequencer, state and registers around the shared multiplier
//
//  channel  direction  handshake                 payload
//  in       input      in_valid / in_ready       in_data  (qtt_pkg::in_item_t)
//  out      output     out_valid / out_ready     out_data (qtt_pkg::out_item_t)
//  cfg      input      cfg_write (no wait)       cfg_index, cfg_data
//
// one item runs 13 multiplies through a single 32x32 multiplier, one partial product per cycle.
// reset clears the stored thrust to zero and loads the register defaults.
// in_ready is high only in idle; a finished result waits in the output register and the
// sequencer holds before its last step while that register is still full.
`timescale 1ns / 1ps
`default_nettype none
module quadrotor_thrust_torque_step_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire qtt_pkg::in_item_t                    in_data,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output qtt_pkg::out_item_t                        out_data,
	input  wire logic                                 cfg_write,
	input  wire logic [qtt_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [qtt_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import qtt_pkg::*;

	qtt_state_t state_q, state_d;

	// configuration registers
	logic [UWORD_W-1:0]       time_step_q, low_thr_q, max_rate_q, rate_lim_q;
	logic signed [WORD_W-1:0] lag_gain_q, ceil_off_q, ceil_gain_q, att_gain_q;

	// item state
	in_item_t                 in_q;
	logic                     lag_q;
	logic                     axis_q;
	logic                     launched_q;
	logic signed [WORD_W-1:0] thrust_q, tx_q, ty_q, tz_q;
	logic signed [ACC_W-1:0]  t_q, u_q, err_q, lim_q;
	out_item_t                out_q;
	logic                     out_valid_q;

	// multiplier hookup
	mul_req_t                mul_req;
	logic signed [ACC_W-1:0] mul_a, mul_b, mul_res;
	logic                    mul_done;
	logic                    is_mul;

	logic                    in_accept;
	logic                    out_load;
	logic signed [ACC_W-1:0] thrust_ext, rate_ext, mbr_ext, change, err_mag_s;
	logic [ACC_W-1:0]        err_mag;
	logic                    t_pos, t_neg, zero_tq;
	logic signed [WORD_W-1:0] tq_word;

	qtt_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.result (mul_res)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign in_accept = in_valid && in_ready;

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mul_req.long_shift = 1'b0;
		case (state_q)
			ST_TT: begin
				mul_a = zext_u(in_q.throttle_cmd);
				mul_b = zext_u(in_q.throttle_cmd);
			end
			ST_C1: begin
				mul_a = zext_u(in_q.throttle_cmd);
				mul_b = K_CTH1;
				mul_req.long_shift = 1'b1;
			end
			ST_C2: begin
				mul_a = t_q;
				mul_b = K_CTH2;
				mul_req.long_shift = 1'b1;
			end
			ST_LAG1: begin
				mul_a = err_q;
				mul_b = sext_s(lag_gain_q);
			end
			ST_LAG2: begin
				mul_a = t_q;
				mul_b = zext_u(time_step_q);
			end
			ST_LIM: begin
				mul_a = zext_u(rate_lim_q);
				mul_b = zext_u(time_step_q);
			end
			ST_CEIL: begin
				mul_a = sext_s(ceil_gain_q);
				mul_b = zext_u(in_q.supply_voltage);
			end
			ST_TQ1: begin
				mul_a = axis_q ? sext_s(in_q.pitch_cmd) : sext_s(in_q.roll_cmd);
				mul_b = K_PQ0;
				mul_req.long_shift = 1'b1;
			end
			ST_TQ2: begin
				mul_a = sext_s(att_gain_q);
				mul_b = t_q;
			end
			ST_TQ3: begin
				mul_a = axis_q ? sext_s(in_q.rate_y) : sext_s(in_q.rate_x);
				mul_b = K_PQ2;
				mul_req.long_shift = 1'b1;
			end
			ST_YAW1: begin
				mul_a = sext_s(in_q.yaw_cmd);
				mul_b = K_R0;
				mul_req.long_shift = 1'b1;
			end
			ST_YAW2: begin
				mul_a = sext_s(in_q.rate_z);
				mul_b = K_R1;
				mul_req.long_shift = 1'b1;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		is_mul = state_q inside {ST_TT, ST_C1, ST_C2, ST_LAG1, ST_LAG2, ST_LIM, ST_CEIL,
		                         ST_TQ1, ST_TQ2, ST_TQ3, ST_YAW1, ST_YAW2};
		mul_req.start = is_mul && !launched_q;
	end

	// clamp, torque cutoff and output load logic
	always_comb begin
		thrust_ext = sext_s(thrust_q);
		err_mag_s  = err_q[ACC_W-1] ? -err_q : err_q;
		err_mag    = $unsigned(err_mag_s);
		if (err_mag < $unsigned(lim_q)) begin
			change = err_q;
		end else if (!err_q[ACC_W-1] && (err_q != '0)) begin
			change = lim_q;
		end else begin
			change = -lim_q;
		end

		rate_ext = axis_q ? sext_s(in_q.rate_y) : sext_s(in_q.rate_x);
		mbr_ext  = zext_u(max_rate_q);
		t_pos    = !t_q[ACC_W-1] && (t_q != '0);
		t_neg    = t_q[ACC_W-1];
		zero_tq  = ((rate_ext > mbr_ext) && t_pos) || ((rate_ext < -mbr_ext) && t_neg);
		tq_word  = zero_tq ? '0 : sat_word(t_q);

		out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_TT;
			ST_TT:    if (mul_done) state_d = ST_C1;
			ST_C1:    if (mul_done) state_d = ST_C2;
			ST_C2:    if (mul_done) state_d = ST_ERR;
			ST_ERR:   state_d = lag_q ? ST_LAG1 : ST_LIM;
			ST_LAG1:  if (mul_done) state_d = ST_LAG2;
			ST_LAG2:  if (mul_done) state_d = ST_TQ1;
			ST_LIM:   if (mul_done) state_d = ST_CEIL;
			ST_CEIL:  if (mul_done) state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_CAND;
			ST_CAND:  state_d = ST_CAP;
			ST_CAP:   state_d = ST_TQ1;
			ST_TQ1:   if (mul_done) state_d = ST_TQ2;
			ST_TQ2:   if (mul_done) state_d = ST_TQ3;
			ST_TQ3:   if (mul_done) state_d = ST_TQ4;
			ST_TQ4:   state_d = axis_q ? ST_YAW1 : ST_TQ1;
			ST_YAW1:  if (mul_done) state_d = ST_YAW2;
			ST_YAW2:  if (mul_done) state_d = ST_OUT;
			ST_OUT:   if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control registers and stored thrust
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			launched_q  <= 1'b0;
			out_valid_q <= 1'b0;
			thrust_q    <= '0;
		end else begin
			state_q <= state_d;
			if (mul_req.start) begin
				launched_q <= 1'b1;
			end else if (mul_done) begin
				launched_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_LAG2 && mul_done) begin
				thrust_q <= sat_word(add_sat(thrust_ext, mul_res));
			end else if (state_q == ST_CAP) begin
				thrust_q <= sat_word((t_q > u_q) ? u_q : t_q);
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= RST_TIME_STEP;
			low_thr_q   <= RST_LOW_THROTTLE;
			max_rate_q  <= RST_MAX_BODY_RATE;
			rate_lim_q  <= RST_THRUST_RATE;
			lag_gain_q  <= RST_LAG_GAIN;
			ceil_off_q  <= RST_CEIL_OFFSET;
			ceil_gain_q <= RST_CEIL_GAIN;
			att_gain_q  <= RST_ATT_GAIN;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_TIME_STEP:     time_step_q <= cfg_data[UWORD_W-1:0];
				CFG_LOW_THROTTLE:  low_thr_q   <= cfg_data[UWORD_W-1:0];
				CFG_MAX_BODY_RATE: max_rate_q  <= cfg_data[UWORD_W-1:0];
				CFG_THRUST_RATE:   rate_lim_q  <= cfg_data[UWORD_W-1:0];
				CFG_LAG_GAIN:      lag_gain_q  <= cfg_data[WORD_W-1:0];
				CFG_CEIL_OFFSET:   ceil_off_q  <= cfg_data[WORD_W-1:0];
				CFG_CEIL_GAIN:     ceil_gain_q <= cfg_data[WORD_W-1:0];
				CFG_ATT_GAIN:      att_gain_q  <= cfg_data[WORD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			in_q   <= in_data;
			lag_q  <= (in_data.throttle_cmd < low_thr_q);
			axis_q <= 1'b0;
		end
		case (state_q)
			ST_TT:    if (mul_done) t_q <= mul_res;
			ST_C1:    if (mul_done) u_q <= add_sat(CTH0_TERM, mul_res);
			ST_C2:    if (mul_done) u_q <= add_sat(u_q, mul_res);
			ST_ERR:   err_q <= sub_sat(u_q, thrust_ext);
			ST_LAG1:  if (mul_done) t_q <= mul_res;
			ST_LIM:   if (mul_done) lim_q <= mul_res;
			ST_CEIL:  if (mul_done) u_q <= add_sat(sext_s(ceil_off_q), mul_res);
			ST_CLAMP: t_q <= change;
			ST_CAND:  t_q <= add_sat(thrust_ext, t_q);
			ST_TQ1: begin
				if (mul_done) begin
					t_q <= sub_sat(mul_res,
					               axis_q ? sext_s(in_q.pitch_angle) : sext_s(in_q.roll_angle));
				end
			end
			ST_TQ2:   if (mul_done) t_q <= mul_res;
			ST_TQ3:   if (mul_done) t_q <= add_sat(t_q, mul_res);
			ST_TQ4: begin
				if (axis_q) begin
					ty_q <= tq_word;
				end else begin
					tx_q   <= tq_word;
					axis_q <= 1'b1;
				end
			end
			ST_YAW1:  if (mul_done) t_q <= mul_res;
			ST_YAW2:  if (mul_done) tz_q <= sat_word(add_sat(t_q, mul_res));
			default: begin
			end
		endcase
		if (out_load) begin
			out_q.thrust_out <= thrust_q;
			out_q.torque_x   <= tx_q;
			out_q.torque_y   <= ty_q;
			out_q.torque_z   <= tz_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

/* tb/sv/thrust_torque_check_pkg.sv */
// thrust and torque predictor plus result scoreboard for the quadrotor step testbench
`timescale 1ns / 1ps
package thrust_torque_check_pkg;
	import qtt_pkg::*;

	// fixed-point layout of the block
	localparam int unsigned Q_BITS    = 16;
	localparam int unsigned COEF_BITS = 40;
	localparam longint      ONE_Q     = 64'sd65536;
	localparam longint      MAX64     = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint      MIN64     = 64'sh8000_0000_0000_0000;

	// airframe coefficients, 40 fraction bits
	localparam longint STICK_SCALE = -64'sd357407250;
	localparam longint RATE_DAMP   = -64'sd26777066378206;
	localparam longint YAW_STICK   = -64'sd5297260106;
	localparam longint YAW_DAMP    = -64'sd5595898458868;
	localparam longint THR_BASE    = 64'sd729944878960;
	localparam longint THR_LIN     = 64'sd818750234;
	localparam longint THR_SQ      = 64'sd2637234;

	localparam int unsigned REPORT_LIMIT = 10;

	function automatic longint sat_add64(longint a, longint b);
		longint r;
		r = a + b;
		if ((a < 0) == (b < 0) && (r < 0) != (a < 0)) return (a < 0) ? MIN64 : MAX64;
		return r;
	endfunction

	function automatic longint sat_sub64(longint a, longint b);
		longint r;
		r = a - b;
		if ((a < 0) != (b < 0) && (r < 0) != (a < 0)) return (a < 0) ? MIN64 : MAX64;
		return r;
	endfunction

	// exact product, scaled down with round half away from zero, clamped to 64 bits
	function automatic longint round_mul(longint a, longint b, int unsigned sh);
		bit [127:0] p;
		bit [63:0]  ma;
		bit [63:0]  mb;
		bit         neg;
		neg = (a < 0) ^ (b < 0);
		ma  = (a < 0) ? -a : a;
		mb  = (b < 0) ? -b : b;
		p   = ma * mb;
		p   = (p + (128'd1 << (sh - 1))) >> sh;
		if (neg) begin
			if (p > 128'h8000_0000_0000_0000) return MIN64;
			return -longint'(p[63:0]);
		end
		if (p > 128'h7FFF_FFFF_FFFF_FFFF) return MAX64;
		return longint'(p[63:0]);
	endfunction

	function automatic logic signed [31:0] to_word(longint x);
		if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (x < -64'sd2147483648) return 32'sh8000_0000;
		return x[31:0];
	endfunction

	function automatic longint widen(logic [31:0] x);
		return longint'(signed'(x));
	endfunction

	class thrust_torque_model;
		// register copies
		longint step_len, lag_level, rate_cap, slew_rate;
		longint lag_coef, ceil_base, ceil_slope, att_gain;
		// stored rotor thrust
		longint thrust_level;
		out_item_t pending_forces[$];
		int unsigned mismatches;

		function new();
			step_len     = longint'(RST_TIME_STEP);
			lag_level    = longint'(RST_LOW_THROTTLE);
			rate_cap     = longint'(RST_MAX_BODY_RATE);
			slew_rate    = longint'(RST_THRUST_RATE);
			lag_coef     = longint'(RST_LAG_GAIN);
			ceil_base    = longint'(RST_CEIL_OFFSET);
			ceil_slope   = longint'(RST_CEIL_GAIN);
			att_gain     = longint'(RST_ATT_GAIN);
			thrust_level = 0;
			mismatches   = 0;
		endfunction

		function void write_register(cfg_reg_t r, logic [31:0] d);
			case (r)
				CFG_TIME_STEP:     step_len   = longint'(d[30:0]);
				CFG_LOW_THROTTLE:  lag_level  = longint'(d[30:0]);
				CFG_MAX_BODY_RATE: rate_cap   = longint'(d[30:0]);
				CFG_THRUST_RATE:   slew_rate  = longint'(d[30:0]);
				CFG_LAG_GAIN:      lag_coef   = widen(d);
				CFG_CEIL_OFFSET:   ceil_base  = widen(d);
				CFG_CEIL_GAIN:     ceil_slope = widen(d);
				CFG_ATT_GAIN:      att_gain   = widen(d);
				default: ;
			endcase
		endfunction

		// quadratic thrust target for a throttle value
		function longint thrust_target(longint thr);
			longint sq;
			sq = round_mul(thr, thr, Q_BITS);
			return sat_add64(sat_add64(round_mul(ONE_Q, THR_BASE, COEF_BITS),
				round_mul(thr, THR_LIN, COEF_BITS)), round_mul(sq, THR_SQ, COEF_BITS));
		endfunction

		// roll or pitch torque, dropped when it would drive an excessive rate further
		function longint attitude_torque(longint cmd, longint angle, longint rate);
			longint inner, t;
			inner = sat_sub64(round_mul(cmd, STICK_SCALE, COEF_BITS), angle);
			t = sat_add64(round_mul(att_gain, inner, Q_BITS), round_mul(rate, RATE_DAMP, COEF_BITS));
			if ((rate > rate_cap && t > 0) || (rate < -rate_cap && t < 0)) t = 0;
			return t;
		endfunction

		// one accepted tick: advance the thrust and queue the expected forces
		function void log_tick(in_item_t it);
			longint     thr, volt, err, nxt, lim, change, ceil_v, cand;
			bit [63:0]  err_mag;
			out_item_t  exp_f;
			thr  = longint'(it.throttle_cmd);
			volt = longint'(it.supply_voltage);
			err  = sat_sub64(thrust_target(thr), thrust_level);
			if (thr < lag_level) begin
				nxt = sat_add64(thrust_level,
					round_mul(round_mul(err, lag_coef, Q_BITS), step_len, Q_BITS));
			end else begin
				lim = round_mul(slew_rate, step_len, Q_BITS);
				err_mag = (err < 0) ? -err : err;
				if (err_mag < 64'(lim)) change = err;
				else change = (err > 0) ? lim : -lim;
				ceil_v = sat_add64(ceil_base, round_mul(ceil_slope, volt, Q_BITS));
				cand = sat_add64(thrust_level, change);
				nxt = (cand > ceil_v) ? ceil_v : cand;
			end
			exp_f.thrust_out = to_word(nxt);
			thrust_level = widen(exp_f.thrust_out);
			exp_f.torque_x = to_word(attitude_torque(widen(it.roll_cmd), widen(it.roll_angle),
				widen(it.rate_x)));
			exp_f.torque_y = to_word(attitude_torque(widen(it.pitch_cmd), widen(it.pitch_angle),
				widen(it.rate_y)));
			exp_f.torque_z = to_word(sat_add64(round_mul(widen(it.yaw_cmd), YAW_STICK, COEF_BITS),
				round_mul(widen(it.rate_z), YAW_DAMP, COEF_BITS)));
			pending_forces.push_back(exp_f);
		endfunction

		// compare one delivered result against the oldest expectation
		function void check_forces(out_item_t got);
			out_item_t exp_f;
			if (pending_forces.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result: %0d %0d %0d %0d", $signed(got.thrust_out),
						$signed(got.torque_x), $signed(got.torque_y), $signed(got.torque_z));
				return;
			end
			exp_f = pending_forces.pop_front();
			if (exp_f.thrust_out != got.thrust_out || exp_f.torque_x != got.torque_x ||
					exp_f.torque_y != got.torque_y || exp_f.torque_z != got.torque_z) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("force mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
						$signed(exp_f.thrust_out), $signed(exp_f.torque_x),
						$signed(exp_f.torque_y), $signed(exp_f.torque_z),
						$signed(got.thrust_out), $signed(got.torque_x),
						$signed(got.torque_y), $signed(got.torque_z));
			end
		endfunction
	endclass

endpackage

/* tb/sv/tb.sv */
// top-level testbench: drives ticks and register settings, checks thrust and torques
`timescale 1ns / 1ps
module tb;
	import qtt_pkg::*;
	import thrust_torque_check_pkg::*;

	localparam int          SETTLE_CYCLES = 100;
	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int          NUM_PHASES    = 6;
	localparam int          PHASE_TICKS   = 155;
	localparam int          HOLD_AT       = 60;
	localparam int          SMAX          = 32'sh7FFF_FFFF;
	localparam int          SMIN          = 32'sh8000_0000;
	localparam int unsigned UMAX          = 32'h7FFF_FFFF;
	localparam int unsigned VOLT_12       = 786432;
	localparam int unsigned VOLT_15       = 983040;
	localparam int unsigned THR_500       = 32768000;
	localparam int          ANG_3         = 196608;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_data;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	thrust_torque_model thrust_sb = new();
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_requests;
	int unsigned cruise_thr;
	int unsigned cycle_count;

	quadrotor_thrust_torque_step_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) thrust_sb.check_forces(out_data);
	end

	// receiver: random stalls plus long hold-offs on request
	initial begin
		int unsigned hold_left;
		int unsigned hold_seen;
		hold_left = 0;
		hold_seen = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = 300 + $urandom_range(200);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready = 1'b0;
			end else begin
				out_ready = arst_n && ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("** quadrotor_thrust_torque_step_core: FAILED **");
		$finish;
	end

	function automatic int sym(int unsigned span);
		return int'($urandom_range(2 * span)) - int'(span);
	endfunction

	function automatic int corner_word();
		case ($urandom_range(4))
			0: return SMIN;
			1: return SMAX;
			2: return 0;
			3: return 1;
			default: return -1;
		endcase
	endfunction

	function automatic int unsigned corner_level();
		case ($urandom_range(3))
			0: return 0;
			1: return 1;
			2: return UMAX;
			default: return 32'h4000_0000;
		endcase
	endfunction

	// body rate, often right at or just past the limit
	function automatic int pick_rate(longint cap);
		case ($urandom_range(19))
			0, 1: return int'(cap);
			2, 3: return -int'(cap);
			4: return int'(cap + 1);
			5: return -int'(cap + 1);
			default: return sym(1310720);
		endcase
	endfunction

	function automatic in_item_t tick(int unsigned thr, int unsigned volt, int rc, int pc,
			int yc, int ra, int pa, int rx, int ry, int rz);
		in_item_t t;
		t.throttle_cmd   = 31'(thr);
		t.supply_voltage = 31'(volt);
		t.roll_cmd       = rc;
		t.pitch_cmd      = pc;
		t.yaw_cmd        = yc;
		t.roll_angle     = ra;
		t.pitch_angle    = pa;
		t.rate_x         = rx;
		t.rate_y         = ry;
		t.rate_z         = rz;
		return t;
	endfunction

	// mostly flight-like ticks around a slowly changing throttle, some corners and noise
	function automatic in_item_t random_tick();
		in_item_t    t;
		int unsigned style;
		longint      lvl;
		style = $urandom_range(99);
		lvl = thrust_sb.lag_level;
		if (style < 15) begin
			t = tick(corner_level(), corner_level(), corner_word(), corner_word(), corner_word(),
				corner_word(), corner_word(), corner_word(), corner_word(), corner_word());
		end else if (style < 35) begin
			t = tick($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom);
		end else begin
			if ($urandom_range(9) == 0) cruise_thr = $urandom_range(65536000);
			t = tick(0, $urandom_range(26 * 65536, 6 * 65536), sym(65536000), sym(65536000),
				sym(65536000), sym(205887), sym(205887), pick_rate(thrust_sb.rate_cap),
				pick_rate(thrust_sb.rate_cap), sym(1310720));
			case ($urandom_range(9))
				0: t.throttle_cmd = 31'(lvl);
				1: t.throttle_cmd = 31'(lvl - 1);
				default: t.throttle_cmd = 31'(cruise_thr + $urandom_range(32768));
			endcase
		end
		return t;
	endfunction

	// offer one tick and hold it until accepted
	task automatic send_tick(input in_item_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = t;
		do @(posedge clk); while (!in_ready);
		thrust_sb.log_tick(t);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] d);
		cfg_write = 1'b1;
		cfg_index = r;
		cfg_data = d;
		thrust_sb.write_register(r, d);
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	// let every outstanding transaction come back before touching registers
	task automatic settle();
		in_valid = 1'b0;
		while (thrust_sb.pending_forces.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// main stimulus
	initial begin
		logic [CFG_DATA_W-1:0] setting [8];
		longint gap;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 22;
		recv_idle_pct = 47;
		hold_requests = 0;
		cruise_thr = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// field extremes under the reset settings
		send_tick(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_tick(tick(UMAX, UMAX, SMAX, SMAX, SMAX, SMIN, SMIN, SMAX, SMAX, SMAX));
		send_tick(tick(UMAX, 0, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN));
		// just below and at the lag-mode throttle
		send_tick(tick(19660799, VOLT_12, 65536, -65536, 0, 6554, -6554, 0, 0, 0));
		send_tick(tick(19660800, VOLT_12, 65536, -65536, 0, 6554, -6554, 0, 0, 0));
		// rate exactly at the limit keeps its torque
		send_tick(tick(THR_500, VOLT_15, 0, 0, 0, -ANG_3, ANG_3, 171573, -171573, 65536));
		// rate past the limit with torque pushing further is zeroed
		send_tick(tick(THR_500, VOLT_15, 0, 0, 0, -ANG_3, ANG_3, 171574, -171574, -65536));
		// rate past the limit with opposing torque is kept
		send_tick(tick(THR_500, VOLT_15, 0, 0, 0, ANG_3, -ANG_3, 171574, -171574, 0));
		// steady climb under the rate limit
		repeat (4) send_tick(tick(THR_500, VOLT_15, 65536000, -65536000, 655360, 0, 0, 0, 0, 0));
		send_tick(tick(THR_500, VOLT_15, 0, 0, SMIN, 0, 0, 0, 0, SMAX));
		send_tick(tick(THR_500, VOLT_15, 0, 0, SMAX, 0, 0, 0, 0, SMIN));
		send_tick(tick(1, VOLT_12, 0, 0, 0, 0, 0, 0, 0, 0));
		// low battery: thrust capped by the voltage ceiling
		send_tick(tick(65536000, 262144, 0, 0, 0, 0, 0, 0, 0, 0));
		settle();

		// thrust error equal to the step limit counts as beyond it
		gap = thrust_sb.thrust_target(0) - thrust_sb.thrust_level;
		if (gap < 0) gap = -gap;
		write_reg(CFG_TIME_STEP, 32'h0001_0000);
		write_reg(CFG_LOW_THROTTLE, '0);
		write_reg(CFG_CEIL_OFFSET, 32'h7FFF_FFFF);
		write_reg(CFG_THRUST_RATE, 32'(gap));
		repeat (2) send_tick(tick(0, VOLT_12, 0, 0, 0, 0, 0, 0, 0, 0));

		// random phases, each under its own register setting
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			case (p)
				0: setting = '{32'(RST_TIME_STEP), 32'(RST_LOW_THROTTLE), 32'(RST_MAX_BODY_RATE),
					32'(RST_THRUST_RATE), RST_LAG_GAIN, RST_CEIL_OFFSET, RST_CEIL_GAIN,
					RST_ATT_GAIN};
				1: setting = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom};
				2: setting = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
					32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
				3: setting = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000,
					32'h8000_0000};
				4: setting = '{$urandom_range(6554, 1), $urandom_range(65536000),
					$urandom_range(655360), $urandom_range(1 << 26), 32'(sym(1 << 20)),
					32'(sym(1 << 22)), 32'(sym(1 << 20)), 32'(sym(1 << 24))};
				default: setting = '{$urandom | 32'h8000_0000, $urandom | 32'h8000_0000,
					$urandom | 32'h8000_0000, $urandom | 32'h8000_0000, $urandom, $urandom,
					$urandom, $urandom};
			endcase
			for (int i = 0; i < 8; i++) write_reg(cfg_reg_t'(i), setting[i]);
			if (p < 2) begin
				send_idle_pct = 22;
				recv_idle_pct = 47;
			end else if (p < 4) begin
				send_idle_pct = 47;
				recv_idle_pct = 22;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int n = 0; n < PHASE_TICKS; n++) begin
				// long receiver hold-off while ticks keep coming
				if (n == HOLD_AT) hold_requests++;
				send_tick(random_tick());
			end
		end
		settle();

		if (thrust_sb.mismatches == 0 && thrust_sb.pending_forces.size() == 0) begin
			$display("** quadrotor_thrust_torque_step_core: PASSED **");
		end else begin
			$display("** quadrotor_thrust_torque_step_core: FAILED **");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/qtt_pkg.sv
sv/qtt_mul.sv
sv/quadrotor_thrust_torque_step_core.sv
tb/sv/thrust_torque_check_pkg.sv
tb/sv/tb.sv
